FILE: design/lebl_pkg.sv
// Shared types and constants for the LED error-code blinker.
package lebl_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SHORT_ON     = 3'd0;
  localparam logic [2:0] REG_LONG_ON      = 3'd1;
  localparam logic [2:0] REG_GAP          = 3'd2;
  localparam logic [2:0] REG_PRE_PAUSE    = 3'd3;
  localparam logic [2:0] REG_CODE_HALF    = 3'd4;
  localparam logic [2:0] REG_END_PAUSE    = 3'd5;
  localparam logic [2:0] REG_REPEAT_LIMIT = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Flashes in each preamble group
  localparam logic [7:0] PREAMBLE_FLASHES = 8'd3;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic [15:0] short_on_ms;
    logic [15:0] long_on_ms;
    logic [15:0] gap_ms;
    logic [15:0] pre_code_pause_ms;
    logic [15:0] code_half_period_ms;
    logic [15:0] end_pause_ms;
    logic [7:0]  repeat_limit;
  } cfg_t;

  typedef struct packed {
    logic        led_on;
    logic [23:0] led_color;
    logic        kick_watchdog;
    logic        reset_request;
    logic        busy_res;
  } res_t;

endpackage

FILE: design/led_error_code_blinker.sv
// LED error-code blinker top level: input register, sequencer and result register.
//
// Each request is either a start (latches code and colour) or a one-millisecond
// tick, and each yields exactly one result: the LED state for that tick, a
// watchdog kick on the first tick of every pass, a reset request on the tick
// that ends the final pass, and a busy flag. One request is taken per clock
// cycle unless the request side is stalled; the result register captures the
// sequencer update of the request held in the input register and offers it as
// that request's result. Stall on the result side holds the result register and,
// once the input register is also full, stalls the request side. Configuration
// writes are taken at any edge with cfg_we_i high and must only be made while idle.
module led_error_code_blinker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [7:0]                      error_code_i,
  input  logic [23:0]                     flash_color_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            led_on_o,
  output logic [23:0]                     led_color_o,
  output logic                            kick_watchdog_o,
  output logic                            reset_request_o,
  output logic                            busy_res_o,
  input  logic                            cfg_we_i,
  input  logic [lebl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lebl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lebl_pkg::*;

  cfg_t        cfg;
  res_t        res, res_q;
  logic        in_vld_q, out_vld_q;
  logic        cmd_q;
  logic [7:0]  code_q;
  logic [23:0] color_q;
  logic        s1_ready, s2_ready, step;

  assign s2_ready   = !out_vld_q || !out_stall_i;
  assign s1_ready   = !in_vld_q || s2_ready;
  assign step       = in_vld_q && s2_ready;
  assign in_stall_o = !s1_ready;

  lebl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lebl_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .command_i     (cmd_q),
    .error_code_i  (code_q),
    .flash_color_i (color_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      cmd_q   <= command_i;
      code_q  <= error_code_i;
      color_q <= flash_color_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign led_on_o        = res_q.led_on;
  assign led_color_o     = res_q.led_color;
  assign kick_watchdog_o = res_q.kick_watchdog;
  assign reset_request_o = res_q.reset_request;
  assign busy_res_o      = res_q.busy_res;

endmodule

FILE: design/lebl_cfg_regs.sv
// Configuration register file of the LED error-code blinker.
module lebl_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lebl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lebl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output lebl_pkg::cfg_t                     cfg_o
);
  import lebl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_on_ms         <= 16'd150;
      cfg_q.long_on_ms          <= 16'd300;
      cfg_q.gap_ms              <= 16'd100;
      cfg_q.pre_code_pause_ms   <= 16'd900;
      cfg_q.code_half_period_ms <= 16'd300;
      cfg_q.end_pause_ms        <= 16'd800;
      cfg_q.repeat_limit        <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SHORT_ON:     cfg_q.short_on_ms         <= cfg_data_i;
        REG_LONG_ON:      cfg_q.long_on_ms          <= cfg_data_i;
        REG_GAP:          cfg_q.gap_ms              <= cfg_data_i;
        REG_PRE_PAUSE:    cfg_q.pre_code_pause_ms   <= cfg_data_i;
        REG_CODE_HALF:    cfg_q.code_half_period_ms <= cfg_data_i;
        REG_END_PAUSE:    cfg_q.end_pause_ms        <= cfg_data_i;
        REG_REPEAT_LIMIT: cfg_q.repeat_limit        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/lebl_seq.sv
// Flash sequencer: phase machine, segment timer and pass counter.
module lebl_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           command_i,
  input  logic [7:0]     error_code_i,
  input  logic [23:0]    flash_color_i,
  input  lebl_pkg::cfg_t cfg_i,
  output lebl_pkg::res_t res_o
);
  import lebl_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S1ON,
    PH_S1OFF,
    PH_GAPA,
    PH_LON,
    PH_LOFF,
    PH_GAPB,
    PH_S2ON,
    PH_S2OFF,
    PH_PAUSE,
    PH_CON,
    PH_COFF,
    PH_END
  } phase_e;

  typedef struct packed {
    phase_e     ph;
    logic [7:0] fc;
    logic [7:0] pc;
    logic       raise;
  } seg_t;

  // Bound on skipped empty off segments after a segment ends; the longest run is three
  localparam int unsigned SKIP_STEPS = 4;

  phase_e      phase_q;
  logic [7:0]  fc_q, pc_q, code_q, code_d;
  logic [15:0] tt_q, tt_d, tt_inc;
  logic [23:0] color_q, color_d;
  seg_t        st;
  res_t        res;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] seg_len(input phase_e ph, input cfg_t c);
    logic [15:0] len;
    case (ph)
      PH_S1ON, PH_S2ON:                       len = at_least_one(c.short_on_ms);
      PH_LON:                                 len = at_least_one(c.long_on_ms);
      PH_S1OFF, PH_S2OFF, PH_LOFF,
      PH_GAPA, PH_GAPB:                       len = c.gap_ms;
      PH_PAUSE:                               len = c.pre_code_pause_ms;
      PH_CON:                                 len = at_least_one(c.code_half_period_ms);
      PH_COFF:                                len = c.code_half_period_ms;
      PH_END:                                 len = c.end_pause_ms;
      default:                                len = 16'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_on(input phase_e ph);
    return (ph == PH_S1ON) || (ph == PH_LON) || (ph == PH_S2ON) || (ph == PH_CON);
  endfunction

  function automatic seg_t next_seg(input seg_t s, input cfg_t c, input logic [7:0] code);
    seg_t       n;
    logic [7:0] fc_inc;
    logic [7:0] pc_inc;
    n      = s;
    fc_inc = s.fc + 8'd1;
    pc_inc = s.pc + 8'd1;
    case (s.ph)
      PH_S1ON: n.ph = PH_S1OFF;
      PH_S1OFF: begin
        if (fc_inc < PREAMBLE_FLASHES) begin
          n.fc = fc_inc;
          n.ph = PH_S1ON;
        end else begin
          n.fc = 8'd0;
          n.ph = PH_GAPA;
        end
      end
      PH_GAPA: n.ph = PH_LON;
      PH_LON:  n.ph = PH_LOFF;
      PH_LOFF: begin
        if (fc_inc < PREAMBLE_FLASHES) begin
          n.fc = fc_inc;
          n.ph = PH_LON;
        end else begin
          n.fc = 8'd0;
          n.ph = PH_GAPB;
        end
      end
      PH_GAPB: n.ph = PH_S2ON;
      PH_S2ON: n.ph = PH_S2OFF;
      PH_S2OFF: begin
        if (fc_inc < PREAMBLE_FLASHES) begin
          n.fc = fc_inc;
          n.ph = PH_S2ON;
        end else begin
          n.fc = 8'd0;
          n.ph = PH_PAUSE;
        end
      end
      PH_PAUSE: begin
        n.fc = 8'd0;
        n.ph = (code == 8'd0) ? PH_END : PH_CON;
      end
      PH_CON: n.ph = PH_COFF;
      PH_COFF: begin
        n.fc = fc_inc;
        n.ph = (fc_inc < code) ? PH_CON : PH_END;
      end
      PH_END: begin
        n.pc = pc_inc;
        n.fc = 8'd0;
        if ((c.repeat_limit != 8'd0) && (pc_inc >= c.repeat_limit)) begin
          n.ph    = PH_IDLE;
          n.raise = 1'b1;
        end else begin
          n.ph = PH_S1ON;
        end
      end
      default: n.ph = PH_IDLE;
    endcase
    return n;
  endfunction

  always_comb begin
    res     = '0;
    st      = '{ph: phase_q, fc: fc_q, pc: pc_q, raise: 1'b0};
    tt_d    = tt_q;
    code_d  = code_q;
    color_d = color_q;
    tt_inc  = tt_q + 16'd1;
    if (command_i == CMD_START) begin
      code_d  = error_code_i;
      color_d = flash_color_i;
      st.ph   = PH_S1ON;
      st.fc   = 8'd0;
      st.pc   = 8'd0;
      tt_d    = 16'd0;
    end else if (phase_q != PH_IDLE) begin
      res.kick_watchdog = (phase_q == PH_S1ON) && (fc_q == 8'd0) && (tt_q == 16'd0);
      res.led_on        = is_on(phase_q);
      res.led_color     = is_on(phase_q) ? color_q : 24'd0;
      tt_d              = tt_inc;
      if (tt_inc >= seg_len(phase_q, cfg_i)) begin
        tt_d = 16'd0;
        st   = next_seg(st, cfg_i, code_q);
        // drop empty off segments; on segments always last a tick
        for (int k = 0; k < SKIP_STEPS; k++) begin
          if ((st.ph != PH_IDLE) && (seg_len(st.ph, cfg_i) == 16'd0)) begin
            st = next_seg(st, cfg_i, code_q);
          end
        end
      end
    end
    res.reset_request = st.raise;
    res.busy_res      = (st.ph != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fc_q    <= 8'd0;
      pc_q    <= 8'd0;
      tt_q    <= 16'd0;
      code_q  <= 8'd0;
      color_q <= 24'd0;
    end else if (step_i) begin
      phase_q <= st.ph;
      fc_q    <= st.fc;
      pc_q    <= st.pc;
      tt_q    <= tt_d;
      code_q  <= code_d;
      color_q <= color_d;
    end
  end

  assign res_o = res;

endmodule

FILE: design/lebl_checker.sv
// Port-level checks for the LED error-code blinker, bound to the top level.
module lebl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        led_on_o,
  input logic [23:0] led_color_o,
  input logic        kick_watchdog_o,
  input logic        reset_request_o,
  input logic        busy_res_o
);

  // LED dark means no colour driven
  a_dark_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !led_on_o |-> led_color_o == 24'd0)
    else $error("colour driven while LED off");

  // A pass opens with the first short flash lit
  a_kick_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kick_watchdog_o |-> led_on_o && busy_res_o)
    else $error("watchdog kick outside first flash");

  // The final pass leaves the block idle; the last tick may still be lit when the
  // off segments behind it are empty
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_request_o |-> !busy_res_o && !kick_watchdog_o)
    else $error("reset request while still playing");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_on_o)
      && $stable(led_color_o) && $stable(busy_res_o))
    else $error("stalled result changed");

endmodule

bind led_error_code_blinker lebl_checker u_lebl_checker (.*);
